>>> sv/imsn_pkg.sv
`timescale 1ns / 1ps

package imsn_pkg;

    // Only the first WINDOW bytes of a file are examined.
    localparam int WINDOW    = 1024;
    localparam int POS_W     = $clog2(WINDOW + 1);
    localparam int NSIG      = 17;
    localparam int SIG_SLOTS = 16;
    localparam int HIST      = 19;
    localparam int SVG_LEN   = 4;
    localparam int WID_LEN   = 18;
    localparam int HGT_LEN   = 19;

    localparam logic [3:0] FMT_NONE = 4'd0;
    localparam logic [3:0] FMT_BMP  = 4'd1;
    localparam logic [3:0] FMT_DDS  = 4'd2;
    localparam logic [3:0] FMT_GIF  = 4'd3;
    localparam logic [3:0] FMT_ICNS = 4'd4;
    localparam logic [3:0] FMT_JPG  = 4'd5;
    localparam logic [3:0] FMT_MNG  = 4'd6;
    localparam logic [3:0] FMT_PBM  = 4'd7;
    localparam logic [3:0] FMT_PGM  = 4'd8;
    localparam logic [3:0] FMT_PPM  = 4'd9;
    localparam logic [3:0] FMT_PNG  = 4'd10;
    localparam logic [3:0] FMT_SVG  = 4'd11;
    localparam logic [3:0] FMT_TIFF = 4'd12;
    localparam logic [3:0] FMT_WEBP = 4'd13;
    localparam logic [3:0] FMT_XBM  = 4'd14;
    localparam logic [3:0] FMT_XPM  = 4'd15;

    // One byte moving from the input register into the scanner.
    typedef struct packed {
        logic       go;
        logic       last;
        logic [7:0] data;
    } step_t;

    localparam logic [7:0] SIG_BYTES [NSIG][SIG_SLOTS] = '{
        '{8'h42, 8'h4D, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h44, 8'h44, 8'h53, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h47, 8'h49, 8'h46, 8'h38, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h69, 8'h63, 8'h6E, 8'h73, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'hFF, 8'hD8, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h8A, 8'h4D, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h31, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h34, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h32, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h35, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h33, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h50, 8'h36, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h4D, 8'h4D, 8'h00, 8'h2A, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h49, 8'h49, 8'h2A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h57, 8'h45, 8'h42, 8'h50, 8'h56, 8'h50, 8'h00, 8'h00},
        '{8'h2F, 8'h2A, 8'h20, 8'h58, 8'h50, 8'h4D, 8'h20, 8'h2A,
          8'h2F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
    };

    localparam logic [4:0] SIG_LEN [NSIG] = '{
        5'd2, 5'd3, 5'd4, 5'd4, 5'd2, 5'd8, 5'd2, 5'd2, 5'd2,
        5'd2, 5'd2, 5'd2, 5'd8, 5'd4, 5'd4, 5'd14, 5'd9
    };

    localparam logic [3:0] SIG_CODE [NSIG] = '{
        FMT_BMP, FMT_DDS, FMT_GIF, FMT_ICNS, FMT_JPG, FMT_MNG,
        FMT_PBM, FMT_PBM, FMT_PGM, FMT_PGM, FMT_PPM, FMT_PPM,
        FMT_PNG, FMT_TIFF, FMT_TIFF, FMT_WEBP, FMT_XPM
    };

    // The four size bytes of a RIFF header match anything.
    localparam logic [SIG_SLOTS-1:0] SIG_WILD [NSIG] = '{
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
        16'h0000, 16'h0000, 16'h0000, 16'h00F0, 16'h0000
    };

    localparam logic [7:0] PAT_SVG [SVG_LEN] = '{8'h3C, 8'h73, 8'h76, 8'h67};

    localparam logic [7:0] PAT_WID [WID_LEN] = '{
        8'h23, 8'h64, 8'h65, 8'h66, 8'h69, 8'h6E, 8'h65, 8'h20, 8'h6D,
        8'h61, 8'h78, 8'h5F, 8'h77, 8'h69, 8'h64, 8'h74, 8'h68, 8'h20
    };

    localparam logic [7:0] PAT_HGT [HGT_LEN] = '{
        8'h23, 8'h64, 8'h65, 8'h66, 8'h69, 8'h6E, 8'h65, 8'h20, 8'h6D,
        8'h61, 8'h78, 8'h5F, 8'h68, 8'h65, 8'h69, 8'h67, 8'h68, 8'h74, 8'h20
    };

endpackage

>>> sv/imsn_scan.sv
`timescale 1ns / 1ps

module imsn_scan
    import imsn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  step_t      step,
    output logic [3:0] code_next
);

    logic [POS_W-1:0] pos_reg;
    logic [NSIG-1:0]  alive_reg;
    logic [7:0]       hist_reg [HIST];
    logic [2:0]       found_reg;

    logic [POS_W-1:0] pos_upd;
    logic [NSIG-1:0]  alive_upd;
    logic [7:0]       hist_upd [HIST];
    logic [2:0]       found_upd;
    logic             in_window;
    logic [3:0]       slot;
    logic             svg_hit;
    logic             wid_hit;
    logic             hgt_hit;
    logic [15:0]      fmt_hit;

    assign in_window = (pos_reg < POS_W'(WINDOW));
    assign slot      = pos_reg[3:0];

    always_comb
    begin
        alive_upd = alive_reg;
        for (int s = 0; s < NSIG; s++)
        begin
            if (in_window && (pos_reg < POS_W'(SIG_LEN[s])) && !SIG_WILD[s][slot] &&
                (SIG_BYTES[s][slot] != step.data))
            begin
                alive_upd[s] = 1'b0;
            end
        end
    end

    always_comb
    begin
        hist_upd[0] = in_window ? step.data : hist_reg[0];
        for (int i = 1; i < HIST; i++)
        begin
            hist_upd[i] = in_window ? hist_reg[i-1] : hist_reg[i];
        end
        pos_upd = in_window ? pos_reg + POS_W'(1) : pos_reg;
    end

    // The newest byte sits at index 0 and faces the last pattern character.
    always_comb
    begin
        svg_hit = (pos_upd >= POS_W'(SVG_LEN));
        for (int i = 0; i < SVG_LEN; i++)
        begin
            if (hist_upd[i] != PAT_SVG[SVG_LEN-1-i])
            begin
                svg_hit = 1'b0;
            end
        end
        wid_hit = (pos_upd >= POS_W'(WID_LEN));
        for (int i = 0; i < WID_LEN; i++)
        begin
            if (hist_upd[i] != PAT_WID[WID_LEN-1-i])
            begin
                wid_hit = 1'b0;
            end
        end
        hgt_hit = (pos_upd >= POS_W'(HGT_LEN));
        for (int i = 0; i < HGT_LEN; i++)
        begin
            if (hist_upd[i] != PAT_HGT[HGT_LEN-1-i])
            begin
                hgt_hit = 1'b0;
            end
        end
        found_upd = found_reg;
        if (in_window)
        begin
            found_upd = found_reg | {hgt_hit, wid_hit, svg_hit};
        end
    end

    always_comb
    begin
        fmt_hit = '0;
        for (int s = 0; s < NSIG; s++)
        begin
            if (alive_upd[s] && (pos_upd >= POS_W'(SIG_LEN[s])))
            begin
                fmt_hit[SIG_CODE[s]] = 1'b1;
            end
        end
        fmt_hit[FMT_SVG] = found_upd[0];
        fmt_hit[FMT_XBM] = found_upd[1] & found_upd[2];

        // Lowest code wins.
        code_next = FMT_NONE;
        for (int c = 15; c >= 1; c--)
        begin
            if (fmt_hit[c])
            begin
                code_next = 4'(c);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            alive_reg <= '1;
            found_reg <= '0;
            for (int i = 0; i < HIST; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else if (step.go)
        begin
            if (step.last)
            begin
                pos_reg   <= '0;
                alive_reg <= '1;
                found_reg <= '0;
                for (int i = 0; i < HIST; i++)
                begin
                    hist_reg[i] <= '0;
                end
            end
            else
            begin
                pos_reg   <= pos_upd;
                alive_reg <= alive_upd;
                found_reg <= found_upd;
                for (int i = 0; i < HIST; i++)
                begin
                    hist_reg[i] <= hist_upd[i];
                end
            end
        end
    end

endmodule

>>> sv/image_magic_sniffer_core.sv
`timescale 1ns / 1ps

// Image format sniffer: feed a file one byte per transaction with last_byte
// set on its final byte; one format_code comes out for each file, and the
// next byte starts a new file. Only the first 1024 bytes are examined.
// Throughput is one byte per cycle unless a final byte must wait: every
// signature and substring compare runs in parallel between the input
// register and the result register, which takes the last byte's code. A
// final byte waits in the input register while an earlier result is held.

module image_magic_sniffer_core
    import imsn_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] format_code
);

    logic       in_valid_reg;
    logic [7:0] in_data_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    logic [3:0] out_code_reg;
    logic       process;
    logic       in_take;
    logic [3:0] code_next;
    step_t      step;

    // A byte that ends a file needs a free result register.
    assign process  = in_valid_reg && (!in_last_reg || !out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !process;
    assign in_take  = in_valid && !in_stall;

    assign step.go   = process;
    assign step.last = in_last_reg;
    assign step.data = in_data_reg;

    imsn_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .code_next (code_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (process)
            begin
                in_valid_reg <= 1'b0;
            end

            if (process && in_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_data_reg <= data_byte;
            in_last_reg <= last_byte;
        end
        if (process && in_last_reg)
        begin
            out_code_reg <= code_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign format_code = out_code_reg;

`ifndef NO_ASSERTIONS
    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid || $past(process && in_last_reg))
        else $error("result appeared without a final byte");

    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> !in_stall)
        else $error("input stalled with an empty input register");

    a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> in_valid_reg)
        else $error("accepted transaction was lost");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import imsn_pkg::*;

    localparam int HEAD_LEN    = 14;
    localparam int SCAN_LEN    = 19;
    localparam int FILE_WINDOW = 1024;
    localparam int SIG_COUNT   = 17;
    localparam int LONG_HOLD   = 400;

    // One fixed prefix signature; byte 0 sits in the top byte of bytes.
    typedef struct packed {
        logic [3:0]   code;
        logic [4:0]   len;
        logic [13:0]  wild;
        logic [111:0] bytes;
    } signature_t;

    class format_scoreboard;
        int unsigned position;
        logic [7:0]  header [HEAD_LEN];
        logic [7:0]  recent [SCAN_LEN];
        bit          svg_seen;
        bit          width_seen;
        bit          height_seen;
        logic [3:0]  expected_formats [$];
        int          errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            position = 0;
            foreach (header[i]) header[i] = 8'h00;
            foreach (recent[i]) recent[i] = 8'h00;
            svg_seen = 1'b0;
            width_seen = 1'b0;
            height_seen = 1'b0;
        endfunction

        static function signature_t signature(int s);
            case (s)
                0:  return '{FMT_BMP,  5'd2, 14'h0, {"BM", 96'h0}};
                1:  return '{FMT_DDS,  5'd3, 14'h0, {"DDS", 88'h0}};
                2:  return '{FMT_GIF,  5'd4, 14'h0, {"GIF8", 80'h0}};
                3:  return '{FMT_ICNS, 5'd4, 14'h0, {"icns", 80'h0}};
                4:  return '{FMT_JPG,  5'd2, 14'h0, {8'hFF, 8'hD8, 96'h0}};
                5:  return '{FMT_MNG,  5'd8, 14'h0,
                             {8'h8A, "MNG", 8'h0D, 8'h0A, 8'h1A, 8'h0A, 48'h0}};
                6:  return '{FMT_PBM,  5'd2, 14'h0, {"P1", 96'h0}};
                7:  return '{FMT_PBM,  5'd2, 14'h0, {"P4", 96'h0}};
                8:  return '{FMT_PGM,  5'd2, 14'h0, {"P2", 96'h0}};
                9:  return '{FMT_PGM,  5'd2, 14'h0, {"P5", 96'h0}};
                10: return '{FMT_PPM,  5'd2, 14'h0, {"P3", 96'h0}};
                11: return '{FMT_PPM,  5'd2, 14'h0, {"P6", 96'h0}};
                12: return '{FMT_PNG,  5'd8, 14'h0,
                             {8'h89, "PNG", 8'h0D, 8'h0A, 8'h1A, 8'h0A, 48'h0}};
                13: return '{FMT_TIFF, 5'd4, 14'h0, {"MM", 8'h00, 8'h2A, 80'h0}};
                14: return '{FMT_TIFF, 5'd4, 14'h0, {"II", 8'h2A, 8'h00, 80'h0}};
                // The four RIFF size bytes match anything.
                15: return '{FMT_WEBP, 5'd14, 14'h00F0, {"RIFF", 32'h0, "WEBPVP"}};
                default: return '{FMT_XPM, 5'd9, 14'h0, {"/* XPM */", 40'h0}};
            endcase
        endfunction

        static function logic [7:0] signature_byte(signature_t m, int i);
            return m.bytes[111 - 8 * i -: 8];
        endfunction

        function bit tail_is(string pat);
            int n;
            n = pat.len();
            if (position < n)
                return 1'b0;
            for (int i = 0; i < n; i++)
                if (recent[i] != pat.getc(n - 1 - i))
                    return 1'b0;
            return 1'b1;
        endfunction

        function bit prefix_ok(int s);
            signature_t m;
            m = signature(s);
            if (position < m.len)
                return 1'b0;
            for (int i = 0; i < m.len; i++)
                if (!m.wild[i] && header[i] != signature_byte(m, i))
                    return 1'b0;
            return 1'b1;
        endfunction

        function logic [3:0] classify();
            signature_t m;
            for (int c = 1; c <= 15; c++)
            begin
                if (c == FMT_SVG)
                begin
                    if (svg_seen)
                        return FMT_SVG;
                end
                else if (c == FMT_XBM)
                begin
                    if (width_seen && height_seen)
                        return FMT_XBM;
                end
                else
                begin
                    for (int s = 0; s < SIG_COUNT; s++)
                    begin
                        m = signature(s);
                        if (m.code == c && prefix_ok(s))
                            return m.code;
                    end
                end
            end
            return FMT_NONE;
        endfunction

        function void note_byte(logic [7:0] b, logic l);
            // Bytes past the window still carry the end-of-file mark.
            if (position < FILE_WINDOW)
            begin
                if (position < HEAD_LEN)
                    header[position] = b;
                for (int i = SCAN_LEN - 1; i > 0; i--)
                    recent[i] = recent[i - 1];
                recent[0] = b;
                position++;
                if (tail_is("<svg"))
                    svg_seen = 1'b1;
                if (tail_is({"#define max_", "width "}))
                    width_seen = 1'b1;
                if (tail_is({"#define max_", "height "}))
                    height_seen = 1'b1;
            end
            if (l)
            begin
                expected_formats.push_back(classify());
                restart();
            end
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_format(logic [3:0] got);
            logic [3:0] want;
            if (expected_formats.size() == 0)
                report_mismatch($sformatf("format_code %0d with no file pending", got));
            else
            begin
                want = expected_formats.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("format_code got %0d, expected %0d",
                                              got, want));
            end
        endtask
    endclass

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] data_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [3:0] format_code;

    format_scoreboard sb = new();
    logic [7:0]       file_buf [$];
    bit               calm = 1'b0;
    bit               hold_request = 1'b0;
    int               stall_left = 0;

    image_magic_sniffer_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .format_code (format_code)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function void append_text(string s);
        for (int i = 0; i < s.len(); i++)
            file_buf.push_back(s.getc(i));
    endfunction

    function void append_noise(int n);
        repeat (n) file_buf.push_back(8'($urandom_range(0, 255)));
    endfunction

    function void append_signature(signature_t m, int keep);
        for (int i = 0; i < keep; i++)
            file_buf.push_back(m.wild[i] ? 8'($urandom_range(0, 255))
                                         : format_scoreboard::signature_byte(m, i));
    endfunction

    function void append_define(string dim);
        append_text({"#define max_", dim, " "});
        append_text("16\n");
    endfunction

    function void corrupt_file();
        int idx;
        if (file_buf.size() == 0)
            return;
        idx = $urandom_range(0, file_buf.size() - 1);
        file_buf[idx] = file_buf[idx] ^ 8'($urandom_range(1, 255));
    endfunction

    task automatic push_byte(logic [7:0] b, logic l);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        last_byte <= l;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_byte(b, l);
    endtask

    task automatic send_file();
        int n;
        if (file_buf.size() == 0)
            file_buf.push_back(8'($urandom_range(0, 255)));
        n = file_buf.size();
        for (int i = 0; i < n; i++)
            push_byte(file_buf[i], i == n - 1);
        file_buf.delete();
    endtask

    task automatic random_file();
        int         kind;
        int         keep;
        int         lines;
        signature_t m;
        kind = $urandom_range(0, 99);
        if (kind < 45)
        begin
            m = format_scoreboard::signature($urandom_range(0, SIG_COUNT - 1));
            keep = m.len;
            if ($urandom_range(0, 99) < 15)
                keep = $urandom_range(0, m.len - 1);
            append_signature(m, keep);
            if ($urandom_range(0, 99) < 10)
                corrupt_file();
            append_noise($urandom_range(0, 10));
            if ($urandom_range(0, 99) < 15)
                append_text("<svg");
        end
        else if (kind < 57)
        begin
            append_noise($urandom_range(0, 6));
            append_text("<svg");
            if ($urandom_range(0, 9) == 0)
                corrupt_file();
            append_noise($urandom_range(0, 6));
        end
        else if (kind < 72)
        begin
            // An X bitmap header needs both lines, in either order.
            append_noise($urandom_range(0, 3));
            lines = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 3;
            if ($urandom_range(0, 1))
            begin
                if (lines[0]) append_define("width");
                if (lines[1]) append_define("height");
            end
            else
            begin
                if (lines[1]) append_define("height");
                if (lines[0]) append_define("width");
            end
            if ($urandom_range(0, 99) < 15)
                corrupt_file();
            append_noise($urandom_range(0, 4));
        end
        else
            append_noise($urandom_range(1, 24));
        send_file();
    endtask

    // The width line ends on the last byte of the window, so the file is an
    // X bitmap; the "<svg" that follows lies past the window and is ignored.
    task automatic long_file();
        append_define("height");
        append_noise(FILE_WINDOW - 22 - 18);
        append_text({"#define max_", "width "});
        append_text("<svg");
        append_noise(8);
        send_file();
    endtask

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                sb.check_format(format_code);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        int sent_files;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        file_buf.push_back(8'h00);
        send_file();
        file_buf.push_back(8'hFF);
        send_file();
        // A file shorter than its prefix is not that format.
        append_text("B");
        send_file();
        append_text("BM");
        send_file();
        append_text("P4");
        send_file();
        append_signature(format_scoreboard::signature(14), 4);
        send_file();
        // Prefix formats win over a later "<svg".
        append_text("BM<svg");
        send_file();

        // The sender keeps offering short files while results are held back.
        calm = 1'b1;
        hold_request = 1'b1;
        repeat (40)
        begin
            append_signature(format_scoreboard::signature(0), 2);
            send_file();
        end
        calm = 1'b0;

        sent_files = 0;
        while (sent_files < 10)
        begin
            random_file();
            sent_files++;
            if (sent_files % 5 == 0)
                calm = ($urandom_range(0, 4) == 0);
        end
        calm = 1'b0;

        long_file();
        repeat (3) random_file();

        in_valid <= 1'b0;
        while (sb.expected_formats.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
